// ----- rtl/pas_pkg.sv -----
// Shared operation codes, widths and control struct for the polynomial add/sub/multiply core
package pas_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;

    // Bit of the operation code that selects multiply (code 3 multiplies too)
    localparam int OP_MUL_BIT = 1;

    localparam int COEFF_W   = 32;
    localparam int OUT_LIMIT = 31;
    localparam int DEG_OUT_W = 5;

    // Per-cycle control from the sequencer to the arithmetic unit
    typedef struct packed {
        logic step_vld;
        logic mul;
        logic sub;
        logic clear;
    } mac_ctrl_t;

endpackage

// ----- rtl/pas_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
module pas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word; the read word is registered, so it appears in the next cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pas_mac.sv -----
// Arithmetic unit: add, subtract or multiply one operand pair, then accumulate
module pas_mac (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pas_pkg::mac_ctrl_t         ctrl,
    input  logic [pas_pkg::COEFF_W-1:0] a_op,
    input  logic [pas_pkg::COEFF_W-1:0] b_op,
    output logic [pas_pkg::COEFF_W-1:0] acc
);

    logic                        prod_vld_reg;
    logic [pas_pkg::COEFF_W-1:0] prod_reg;
    logic [pas_pkg::COEFF_W-1:0] acc_reg;
    logic [pas_pkg::COEFF_W-1:0] prod_next;

    // Form the term: low word of the product, or the sum or difference
    always_comb begin
        if (ctrl.mul) begin
            prod_next = a_op * b_op;
        end else if (ctrl.sub) begin
            prod_next = a_op - b_op;
        end else begin
            prod_next = a_op + b_op;
        end
    end

    // Register the term, then fold it into the accumulator, or zero the accumulator on clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            prod_vld_reg <= ctrl.step_vld;
            if (ctrl.clear) begin
                acc_reg <= '0;
            end else if (prod_vld_reg) begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/polynomial_add_sub_multiply_core.sv -----
// Top level: coefficient stores, load handling and the result sequencer
//
// Usage:
//   Load words on the s_ channel: each writes s_coefficient at s_degree into the
//   first (s_operand_select 0) or second store; degrees of MAX_TERMS or more are
//   not stored. The word with s_last_term set starts the operation held in the
//   cfg_ register: add, subtract (first minus second) or multiply.
//   Results leave on the m_ channel, degree 0 upward, one word per coefficient,
//   m_last_result on the highest. Add and subtract give min(MAX_TERMS, 31)
//   words, multiply gives min(2*MAX_TERMS-1, 31). Both stores then read as zero.
// Timing:
//   Load words are taken while s_ready is high. Result words are built at one
//   multiply-accumulate per cycle, fed by one read port on each coefficient RAM,
//   followed by a drain of the read / multiply / accumulate pipe. s_ready is low
//   from the last load word until the final result word is taken.
// Reset and stall:
//   Reset clears the stores (per-entry valid bits) and sets the operation to add.
//   While m_ready is low the result word holds and the sequencer waits.
module polynomial_add_sub_multiply_core #(
    parameter int MAX_TERMS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration word
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_operation,
    // Load words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operand_select,
    input  logic [3:0]                        s_degree,
    input  logic signed [31:0]                s_coefficient,
    input  logic                              s_last_term,
    // Result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pas_pkg::DEG_OUT_W-1:0]     m_result_degree,
    output logic signed [31:0]                m_result_coeff,
    output logic                              m_last_result
);

    localparam int AW        = $clog2(MAX_TERMS);
    localparam int ADD_COUNT = (MAX_TERMS < pas_pkg::OUT_LIMIT) ? MAX_TERMS
                                                                : pas_pkg::OUT_LIMIT;
    localparam int MUL_COUNT = (2 * MAX_TERMS - 1 < pas_pkg::OUT_LIMIT) ? 2 * MAX_TERMS - 1
                                                                        : pas_pkg::OUT_LIMIT;
    localparam logic [pas_pkg::DEG_OUT_W-1:0] ADD_LAST = pas_pkg::DEG_OUT_W'(ADD_COUNT - 1);
    localparam logic [pas_pkg::DEG_OUT_W-1:0] MUL_LAST = pas_pkg::DEG_OUT_W'(MUL_COUNT - 1);
    localparam logic [AW-1:0] I_LAST     = AW'(MAX_TERMS - 1);
    localparam logic [1:0]    DRAIN_LAST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t                            state_reg;
    logic [1:0]                        op_reg;
    logic [MAX_TERMS-1:0]              a_vld_reg;
    logic [MAX_TERMS-1:0]              b_vld_reg;
    logic [pas_pkg::DEG_OUT_W-1:0]     k_reg;
    logic [AW-1:0]                     i_reg;
    logic [1:0]                        drain_reg;
    logic                              s1_vld_reg;
    logic                              a_ok_reg;
    logic                              b_ok_reg;
    logic                              m_valid_reg;
    logic [pas_pkg::DEG_OUT_W-1:0]     deg_reg;
    logic [pas_pkg::COEFF_W-1:0]       coeff_reg;
    logic                              last_reg;

    logic                              mul_mode;
    logic                              deg_ok;
    logic [AW-1:0]                     wr_idx;
    logic [5:0]                        j_diff;
    logic                              j_ok;
    logic [AW-1:0]                     a_addr;
    logic [AW-1:0]                     b_addr;
    logic                              step_ok;
    logic                              issue_end;
    logic                              drain_done;
    logic [pas_pkg::DEG_OUT_W-1:0]     last_k;
    logic [pas_pkg::COEFF_W-1:0]       a_rdata;
    logic [pas_pkg::COEFF_W-1:0]       b_rdata;
    logic [pas_pkg::COEFF_W-1:0]       acc;
    logic                              load_acc;
    pas_pkg::mac_ctrl_t                mac_ctrl;

    assign mul_mode = op_reg[pas_pkg::OP_MUL_BIT];
    assign last_k   = mul_mode ? MUL_LAST : ADD_LAST;

    // Decode the load word
    assign load_acc = (state_reg == ST_IDLE) && s_valid;
    assign deg_ok   = 6'(s_degree) < 6'(MAX_TERMS);
    assign wr_idx   = AW'(s_degree);

    // Read addresses: first[i] and second[k-i] for multiply, both at k otherwise
    assign j_diff = 6'(k_reg) - 6'(i_reg);
    assign j_ok   = !j_diff[5] && (j_diff < 6'(MAX_TERMS));
    always_comb begin
        if (mul_mode) begin
            a_addr  = i_reg;
            b_addr  = j_diff[AW-1:0];
            step_ok = j_ok;
        end else begin
            a_addr  = k_reg[AW-1:0];
            b_addr  = k_reg[AW-1:0];
            step_ok = 1'b1;
        end
    end
    assign issue_end  = !mul_mode || (i_reg == I_LAST);
    assign drain_done = (state_reg == ST_DRAIN) && (drain_reg == DRAIN_LAST);

    pas_ram #(
        .WIDTH (pas_pkg::COEFF_W),
        .DEPTH (MAX_TERMS)
    ) u_first_ram (
        .aclk    (aclk),
        .wr_en   (load_acc && deg_ok && !s_operand_select),
        .wr_addr (wr_idx),
        .wr_data (s_coefficient),
        .rd_addr (a_addr),
        .rd_data (a_rdata)
    );

    pas_ram #(
        .WIDTH (pas_pkg::COEFF_W),
        .DEPTH (MAX_TERMS)
    ) u_second_ram (
        .aclk    (aclk),
        .wr_en   (load_acc && deg_ok && s_operand_select),
        .wr_addr (wr_idx),
        .wr_data (s_coefficient),
        .rd_addr (b_addr),
        .rd_data (b_rdata)
    );

    // Drive the arithmetic unit; entries never written since a clear read as zero
    assign mac_ctrl.step_vld = s1_vld_reg;
    assign mac_ctrl.mul      = mul_mode;
    assign mac_ctrl.sub      = (op_reg == pas_pkg::OP_SUB);
    assign mac_ctrl.clear    = drain_done;

    pas_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .a_op    (a_ok_reg ? a_rdata : '0),
        .b_op    (b_ok_reg ? b_rdata : '0),
        .acc     (acc)
    );

    // Sequencer: load, issue reads for one degree, drain, present the word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= pas_pkg::OP_ADD;
            a_vld_reg   <= '0;
            b_vld_reg   <= '0;
            k_reg       <= '0;
            i_reg       <= '0;
            drain_reg   <= '0;
            s1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                op_reg <= cfg_operation;
            end
            s1_vld_reg <= (state_reg == ST_ISSUE) && step_ok;
            a_ok_reg   <= a_vld_reg[a_addr];
            b_ok_reg   <= b_vld_reg[b_addr];

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (deg_ok) begin
                            if (s_operand_select) begin
                                b_vld_reg[wr_idx] <= 1'b1;
                            end else begin
                                a_vld_reg[wr_idx] <= 1'b1;
                            end
                        end
                        if (s_last_term) begin
                            k_reg     <= '0;
                            i_reg     <= '0;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    if (issue_end) begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (drain_reg == DRAIN_LAST) begin
                        m_valid_reg <= 1'b1;
                        deg_reg     <= k_reg;
                        coeff_reg   <= acc;
                        last_reg    <= (k_reg == last_k);
                        state_reg   <= ST_OUT;
                    end else begin
                        drain_reg <= drain_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (last_reg) begin
                            a_vld_reg <= '0;
                            b_vld_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            i_reg     <= '0;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_result_degree = deg_reg;
    assign m_result_coeff  = coeff_reg;
    assign m_last_result   = last_reg;

endmodule

// ----- bench/tb_polynomial_add_sub_multiply_core.sv -----
// Self-checking bench for the polynomial add/sub/multiply core: random load words, checked results
module tb_polynomial_add_sub_multiply_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TERMS         = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 60;
    localparam int RANDOM_LOADS  = 85;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_MAX    = 10;

    // Multiply codes; the core multiplies whenever the upper bit is set
    localparam logic [1:0] OP_MUL     = 2'd2;
    localparam logic [1:0] OP_MUL_ALT = 2'd3;

    typedef enum logic [1:0] {
        K_LOAD,
        K_CFG,
        K_DRAIN
    } word_kind_t;

    typedef struct {
        word_kind_t  kind;
        logic        sel;
        logic [3:0]  deg;
        logic [31:0] coeff;
        logic        last;
        logic [1:0]  op;
    } pending_word_t;

    typedef struct packed {
        logic [pas_pkg::DEG_OUT_W-1:0] deg;
        logic [31:0]                   coeff;
        logic                          last;
    } coeff_word_t;

    logic              aclk             = 1'b0;
    logic              aresetn          = 1'b0;
    logic              cfg_valid        = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_operation    = pas_pkg::OP_ADD;
    logic              s_valid          = 1'b0;
    logic              s_ready;
    logic              s_operand_select = 1'b0;
    logic [3:0]        s_degree         = 4'd0;
    logic signed [31:0] s_coefficient   = 32'sd0;
    logic              s_last_term      = 1'b0;
    logic              m_valid;
    logic              m_ready          = 1'b0;
    logic [pas_pkg::DEG_OUT_W-1:0] m_result_degree;
    logic signed [31:0] m_result_coeff;
    logic              m_last_result;

    // Mirror of the core's state
    logic [31:0]   first_store  [0:TERMS-1];
    logic [31:0]   second_store [0:TERMS-1];
    logic [1:0]    op_reg = pas_pkg::OP_ADD;

    pending_word_t pending_words[$];
    coeff_word_t   expected_coeffs[$];

    int  err_count   = 0;
    int  cycle_count = 0;
    int  send_gap    = 0;
    int  settle_cnt  = 0;
    int  recv_stall  = 0;
    bit  calm_send   = 1'b0;
    bit  calm_recv   = 1'b0;

    polynomial_add_sub_multiply_core #(
        .MAX_TERMS(TERMS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_operation   (cfg_operation),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operand_select(s_operand_select),
        .s_degree        (s_degree),
        .s_coefficient   (s_coefficient),
        .s_last_term     (s_last_term),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_degree (m_result_degree),
        .m_result_coeff  (m_result_coeff),
        .m_last_result   (m_last_result)
    );

    always #5 aclk = ~aclk;

    // Mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Lean on the wrap-around corners
    function automatic logic [31:0] rand_coeff();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4, 5: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // Store one coefficient; on the last word compute the result words and clear
    task automatic apply_load(input logic sel, input logic [3:0] deg,
                              input logic [31:0] coeff, input logic last);
        logic [31:0] acc [0:2*TERMS-2];
        int          n;
        coeff_word_t w;
        if (sel)
            second_store[deg] = coeff;
        else
            first_store[deg] = coeff;
        if (!last)
            return;
        for (int k = 0; k < 2 * TERMS - 1; k++)
            acc[k] = '0;
        if (op_reg[pas_pkg::OP_MUL_BIT]) begin
            for (int i = 0; i < TERMS; i++)
                for (int j = 0; j < TERMS; j++)
                    acc[i + j] = acc[i + j] + first_store[i] * second_store[j];
            n = 2 * TERMS - 1;
        end else begin
            for (int i = 0; i < TERMS; i++)
                acc[i] = (op_reg == pas_pkg::OP_SUB) ? first_store[i] - second_store[i]
                                                     : first_store[i] + second_store[i];
            n = TERMS;
        end
        if (n > pas_pkg::OUT_LIMIT)
            n = pas_pkg::OUT_LIMIT;
        for (int i = 0; i < n; i++) begin
            w.deg   = pas_pkg::DEG_OUT_W'(i);
            w.coeff = acc[i];
            w.last  = (i == n - 1);
            expected_coeffs.push_back(w);
        end
        for (int i = 0; i < TERMS; i++) begin
            first_store[i]  = '0;
            second_store[i] = '0;
        end
    endtask

    task automatic push_load(input logic sel, input logic [3:0] deg,
                             input logic [31:0] coeff, input logic last);
        pending_word_t w;
        w.kind  = K_LOAD;
        w.sel   = sel;
        w.deg   = deg;
        w.coeff = coeff;
        w.last  = last;
        w.op    = pas_pkg::OP_ADD;
        pending_words.push_back(w);
    endtask

    task automatic push_ctrl(input word_kind_t kind, input logic [1:0] op);
        pending_word_t w;
        w.kind  = kind;
        w.sel   = 1'b0;
        w.deg   = '0;
        w.coeff = '0;
        w.last  = 1'b0;
        w.op    = op;
        pending_words.push_back(w);
    endtask

    // Driver: hold each word until taken, config and drain only once idle
    always @(posedge aclk) begin
        pending_word_t w;
        logic nxt_s_valid;
        logic nxt_cfg_valid;
        logic s_fire;
        logic c_fire;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            cfg_valid  <= 1'b0;
            send_gap   = 0;
            settle_cnt = 0;
        end else begin
            s_fire        = s_valid && s_ready;
            c_fire        = cfg_valid && cfg_ready;
            nxt_s_valid   = s_valid && !s_fire;
            nxt_cfg_valid = cfg_valid && !c_fire;
            if (s_fire)
                apply_load(s_operand_select, s_degree, s_coefficient, s_last_term);
            if (c_fire)
                op_reg = cfg_operation;

            // Count quiet cycles with nothing outstanding
            if (expected_coeffs.size() == 0 && !s_valid && !cfg_valid)
                settle_cnt++;
            else
                settle_cnt = 0;

            if ($urandom_range(0, 63) == 0)
                calm_send = !calm_send;

            if (!nxt_s_valid && !nxt_cfg_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() != 0) begin
                    w = pending_words[0];
                    case (w.kind)
                        K_LOAD: begin
                            void'(pending_words.pop_front());
                            nxt_s_valid = 1'b1;
                            s_operand_select <= w.sel;
                            s_degree         <= w.deg;
                            s_coefficient    <= w.coeff;
                            s_last_term      <= w.last;
                            send_gap = pick_gap(calm_send);
                        end
                        K_CFG: begin
                            if (settle_cnt >= SETTLE_CYCLES) begin
                                void'(pending_words.pop_front());
                                nxt_cfg_valid = 1'b1;
                                cfg_operation <= w.op;
                                send_gap = pick_gap(calm_send);
                            end
                        end
                        default: begin
                            if (settle_cnt >= SETTLE_CYCLES)
                                void'(pending_words.pop_front());
                        end
                    endcase
                end
            end
            s_valid   <= nxt_s_valid;
            cfg_valid <= nxt_cfg_valid;
        end
    end

    // Monitor: check each taken result word against the oldest expectation
    always @(posedge aclk) begin
        coeff_word_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_coeffs.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected result word: degree %0d coeff %h last %0b",
                                 m_result_degree, m_result_coeff, m_last_result);
                end else begin
                    want = expected_coeffs.pop_front();
                    if (m_result_degree !== want.deg || m_result_coeff !== want.coeff ||
                        m_last_result !== want.last) begin
                        err_count++;
                        if (err_count <= REPORT_MAX) begin
                            $display("result mismatch: expected degree %0d coeff %h last %0b",
                                     want.deg, want.coeff, want.last);
                            $display("                 got degree %0d coeff %h last %0b",
                                     m_result_degree, m_result_coeff, m_last_result);
                        end
                    end
                end
            end

            if ($urandom_range(0, 63) == 0)
                calm_recv = !calm_recv;

            // Stall for the chosen count, then raise m_ready again
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_stall = pick_gap(calm_recv);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [1:0] op_codes [0:3];
        int         loaded;
        int         n;
        op_codes = '{pas_pkg::OP_ADD, pas_pkg::OP_SUB, OP_MUL, OP_MUL_ALT};
        for (int i = 0; i < TERMS; i++) begin
            first_store[i]  = '0;
            second_store[i] = '0;
        end

        // Add: wrap at the top, extremes at both ends of the store
        push_ctrl(K_CFG, pas_pkg::OP_ADD);
        push_load(1'b0, 4'd0, 32'h7FFF_FFFF, 1'b0);
        push_load(1'b1, 4'd0, 32'h0000_0001, 1'b0);
        push_load(1'b0, 4'd15, 32'h8000_0000, 1'b0);
        push_load(1'b1, 4'd15, 32'h8000_0000, 1'b1);
        // Subtract: wrap at the bottom
        push_ctrl(K_CFG, pas_pkg::OP_SUB);
        push_load(1'b0, 4'd0, 32'h8000_0000, 1'b0);
        push_load(1'b1, 4'd0, 32'h0000_0001, 1'b0);
        push_load(1'b1, 4'd15, 32'hFFFF_FFFF, 1'b0);
        push_load(1'b0, 4'd7, 32'hFFFF_FFFF, 1'b1);
        // Multiply: highest degree term and product overflow
        push_ctrl(K_CFG, OP_MUL);
        push_load(1'b0, 4'd15, 32'h8000_0000, 1'b0);
        push_load(1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0);
        push_load(1'b1, 4'd15, 32'h7FFF_FFFF, 1'b0);
        push_load(1'b1, 4'd0, 32'hFFFF_FFFF, 1'b1);
        // Unused code multiplies as well
        push_ctrl(K_CFG, OP_MUL_ALT);
        push_load(1'b0, 4'd3, 32'd5, 1'b0);
        push_load(1'b1, 4'd2, 32'd7, 1'b1);
        // Last word alone on cleared stores, then an overwritten entry
        push_ctrl(K_CFG, pas_pkg::OP_ADD);
        push_load(1'b1, 4'd9, 32'd0, 1'b1);
        push_load(1'b0, 4'd4, 32'd10, 1'b0);
        push_load(1'b0, 4'd4, 32'hFFFF_FFFD, 1'b0);
        push_load(1'b1, 4'd4, 32'd1, 1'b1);
        push_ctrl(K_DRAIN, pas_pkg::OP_ADD);

        // Random phases, each closed by a last word
        loaded = 0;
        while (loaded < RANDOM_LOADS) begin
            if ($urandom_range(0, 2) == 0)
                push_ctrl(K_CFG, op_codes[$urandom_range(0, 3)]);
            if ($urandom_range(0, 9) == 0)
                push_ctrl(K_DRAIN, pas_pkg::OP_ADD);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                push_load(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                          rand_coeff(), k == n - 1);
            loaded += n;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain everything, then give the core time to misbehave
        while (pending_words.size() != 0 || s_valid || cfg_valid || expected_coeffs.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        err_count += expected_coeffs.size();
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
